[rtl/lighting_bus_session_sequencer_unit_assert.svh]
// Assertion macros for the session sequencer core.
// Each macro checks a property at the rising clock edge, disabled during reset.
`ifndef LIGHTING_BUS_SESSION_SEQUENCER_UNIT_ASSERT_SVH
`define LIGHTING_BUS_SESSION_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LBSS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbss assertion failed");

// Next-cycle implication.
`define LBSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbss assertion failed");

`else

`define LBSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define LBSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/lbss_pkg.sv]
package lbss_pkg;

  // Field widths.
  localparam int DATA_BITS      = 24;
  localparam int TIMER_BITS     = 16;
  localparam int TICK_REG_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  // Reset values of the tick registers (settling and reply timeout maxima).
  localparam logic [TICK_REG_BITS-1:0] SETTLE_TICKS_DEFAULT     = 16'd14;
  localparam logic [TICK_REG_BITS-1:0] REPLY_WAIT_TICKS_DEFAULT = 16'd12;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLY_WAIT = 2'd2;

  // Item kinds.
  localparam logic [1:0] FUNC_REQUEST = 2'd0;
  localparam logic [1:0] FUNC_BUS     = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  // Request kinds.
  localparam logic [1:0] MSG_SEND       = 2'd0;
  localparam logic [1:0] MSG_SEND_TWICE = 2'd1;
  localparam logic [1:0] MSG_QUERY      = 2'd2;
  localparam logic [1:0] MSG_INVALID    = 2'd3;

  // Physical-layer event codes.
  localparam logic [3:0] BUS_FWD_DONE    = 4'd0;
  localparam logic [3:0] BUS_BWD_DONE    = 4'd1;
  localparam logic [3:0] BUS_START_ERR   = 4'd2;
  localparam logic [3:0] BUS_STOP_ERR    = 4'd3;
  localparam logic [3:0] BUS_FWD_ERR     = 4'd4;
  localparam logic [3:0] BUS_BWD_ERR     = 4'd5;
  localparam logic [3:0] BUS_DATA_VIOL   = 4'd6;
  localparam logic [3:0] BUS_TIMING_VIOL = 4'd7;
  localparam logic [3:0] BUS_SIZE_VIOL   = 4'd8;

  // Request status codes.
  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_NOT_ENABLED = 3'd1;
  localparam logic [2:0] STAT_BUSY        = 3'd2;
  localparam logic [2:0] STAT_INVALID     = 3'd3;
  localparam logic [2:0] STAT_REFUSED     = 3'd4;

  // Session event codes.
  localparam logic [1:0] EV_DONE       = 2'd0;
  localparam logic [1:0] EV_COLLISION  = 2'd1;
  localparam logic [1:0] EV_TIMEOUT    = 2'd2;
  localparam logic [1:0] EV_UNEXPECTED = 2'd3;

  // Session states.
  localparam logic [1:0] ST_READY    = 2'd0;
  localparam logic [1:0] ST_PROGRESS = 2'd1;
  localparam logic [1:0] ST_SETTLING = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0]           func;
    logic [1:0]           msg_kind;
    logic [1:0]           frame_kind;
    logic [DATA_BITS-1:0] frame_bits;
    logic [3:0]           bus_event;
    logic [7:0]           reply_byte;
    logic                 phy_accept;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]           exec_status;
    logic                 send_strobe;
    logic [1:0]           send_kind;
    logic [DATA_BITS-1:0] send_bits;
    logic                 event_valid;
    logic [1:0]           event_code;
    logic [1:0]           event_msg_kind;
    logic [DATA_BITS-1:0] event_data;
    logic                 busy_res;
  } out_t;

endpackage

[rtl/lighting_bus_session_sequencer_unit.sv]
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_stall    lbss_pkg::in_t
// out       output     out_valid / out_stall  lbss_pkg::out_t
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each word passes through the input register and then the result register.
// A new word is accepted every cycle while the result side keeps taking words.
// The session update is a single pass of next-state logic between the two registers.
// Reset is synchronous and returns the session to ready with default tick counts.
// A stall on the result side backs up through the input register to in_stall.
module lighting_bus_session_sequencer_unit #(
  parameter int TIMER_BITS = lbss_pkg::TIMER_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lbss_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lbss_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lbss_pkg::TICK_REG_BITS-1:0]  cfg_data
);

  logic           advance;
  logic           item_valid;
  logic           step;
  lbss_pkg::in_t  item;
  lbss_pkg::out_t res;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;
  assign step      = item_valid && advance;

  lbss_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lbss_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item),
    .res       (res)
  );

  lbss_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/lbss_in_reg.sv]
module lbss_in_reg (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  lbss_pkg::in_t in_data,
  input  logic         advance,
  output logic         item_valid,
  output lbss_pkg::in_t item
);

  logic load;

  // The register holds its word until the result stage can take it.
  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  // Valid bit of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_data;
    end
  end

endmodule

[rtl/lbss_core.sv]
`include "lighting_bus_session_sequencer_unit_assert.svh"

module lbss_core #(
  parameter int TIMER_BITS = lbss_pkg::TIMER_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lbss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lbss_pkg::TICK_REG_BITS-1:0]  cfg_data,
  input  logic                                step,
  input  lbss_pkg::in_t                       item,
  output lbss_pkg::out_t                      res
);

  // Configuration registers.
  logic                               enabled;
  logic [lbss_pkg::TICK_REG_BITS-1:0] settle_ticks;
  logic [lbss_pkg::TICK_REG_BITS-1:0] reply_wait_ticks;

  // Session state and its next values.
  logic [1:0]                     session_state, session_state_next;
  logic [1:0]                     current_kind, current_kind_next;
  logic                           repeat_pending, repeat_pending_next;
  logic [1:0]                     stored_frame_kind, stored_frame_kind_next;
  logic [lbss_pkg::DATA_BITS-1:0] stored_data, stored_data_next;
  logic [TIMER_BITS-1:0]          countdown, countdown_next;
  logic                           countdown_running, countdown_running_next;

  logic [lbss_pkg::DATA_BITS-1:0] reply_ext;
  logic                           report;
  logic [1:0]                     report_code;

  assign reply_ext = lbss_pkg::DATA_BITS'(item.reply_byte);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled          <= 1'b0;
      settle_ticks     <= lbss_pkg::SETTLE_TICKS_DEFAULT;
      reply_wait_ticks <= lbss_pkg::REPLY_WAIT_TICKS_DEFAULT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lbss_pkg::CFG_ENABLED:    enabled          <= cfg_data[0];
        lbss_pkg::CFG_SETTLE:     settle_ticks     <= cfg_data;
        lbss_pkg::CFG_REPLY_WAIT: reply_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state and result logic for one word.
  always_comb begin
    session_state_next     = session_state;
    current_kind_next      = current_kind;
    repeat_pending_next    = repeat_pending;
    stored_frame_kind_next = stored_frame_kind;
    stored_data_next       = stored_data;
    countdown_next         = countdown;
    countdown_running_next = countdown_running;
    report                 = 1'b0;
    report_code            = lbss_pkg::EV_DONE;
    res                    = '0;

    case (item.func)
      lbss_pkg::FUNC_REQUEST: begin
        if (!enabled) begin
          res.exec_status = lbss_pkg::STAT_NOT_ENABLED;
        end else if (session_state != lbss_pkg::ST_READY) begin
          res.exec_status = lbss_pkg::STAT_BUSY;
        end else if (item.msg_kind == lbss_pkg::MSG_INVALID) begin
          res.exec_status = lbss_pkg::STAT_INVALID;
        end else begin
          // The frame is offered even if the physical layer refuses it.
          repeat_pending_next = (item.msg_kind == lbss_pkg::MSG_SEND_TWICE);
          res.send_strobe     = 1'b1;
          res.send_kind       = item.frame_kind;
          res.send_bits       = item.frame_bits;
          if (!item.phy_accept) begin
            res.exec_status = lbss_pkg::STAT_REFUSED;
          end else begin
            stored_frame_kind_next = item.frame_kind;
            current_kind_next      = item.msg_kind;
            stored_data_next       = item.frame_bits;
            session_state_next     = lbss_pkg::ST_PROGRESS;
          end
        end
      end

      lbss_pkg::FUNC_BUS: begin
        case (item.bus_event) inside
          lbss_pkg::BUS_FWD_DONE: begin
            if (current_kind == lbss_pkg::MSG_SEND_TWICE && repeat_pending) begin
              countdown_next         = TIMER_BITS'(settle_ticks);
              countdown_running_next = 1'b1;
            end else if (current_kind == lbss_pkg::MSG_SEND ||
                         current_kind == lbss_pkg::MSG_SEND_TWICE) begin
              session_state_next     = lbss_pkg::ST_SETTLING;
              countdown_next         = TIMER_BITS'(settle_ticks);
              countdown_running_next = 1'b1;
              report                 = 1'b1;
              report_code            = lbss_pkg::EV_DONE;
            end else if (current_kind == lbss_pkg::MSG_QUERY) begin
              countdown_next         = TIMER_BITS'(reply_wait_ticks);
              countdown_running_next = 1'b1;
            end
          end
          lbss_pkg::BUS_BWD_DONE: begin
            session_state_next     = lbss_pkg::ST_SETTLING;
            countdown_next         = TIMER_BITS'(settle_ticks);
            countdown_running_next = 1'b1;
            stored_data_next       = reply_ext;
            report                 = 1'b1;
            report_code            = (current_kind == lbss_pkg::MSG_QUERY) ?
                                     lbss_pkg::EV_DONE : lbss_pkg::EV_UNEXPECTED;
          end
          lbss_pkg::BUS_START_ERR, lbss_pkg::BUS_STOP_ERR, lbss_pkg::BUS_FWD_ERR: begin
            report             = 1'b1;
            report_code        = lbss_pkg::EV_COLLISION;
            session_state_next = lbss_pkg::ST_READY;
          end
          lbss_pkg::BUS_BWD_ERR, lbss_pkg::BUS_DATA_VIOL,
          lbss_pkg::BUS_TIMING_VIOL, lbss_pkg::BUS_SIZE_VIOL: begin
            stored_data_next   = reply_ext;
            report             = 1'b1;
            report_code        = lbss_pkg::EV_UNEXPECTED;
            session_state_next = lbss_pkg::ST_READY;
          end
          default: ;
        endcase
      end

      lbss_pkg::FUNC_TICK: begin
        if (countdown_running) begin
          if (countdown <= TIMER_BITS'(1)) begin
            countdown_next         = '0;
            countdown_running_next = 1'b0;
            // Expiry acts only while enabled and not ready.
            if (enabled && session_state != lbss_pkg::ST_READY) begin
              if (current_kind == lbss_pkg::MSG_SEND_TWICE && repeat_pending) begin
                res.send_strobe = 1'b1;
                res.send_kind   = stored_frame_kind;
                res.send_bits   = stored_data;
                if (!item.phy_accept) begin
                  report             = 1'b1;
                  report_code        = lbss_pkg::EV_COLLISION;
                  session_state_next = lbss_pkg::ST_READY;
                end
                repeat_pending_next = 1'b0;
              end else if (current_kind == lbss_pkg::MSG_SEND ||
                           current_kind == lbss_pkg::MSG_SEND_TWICE) begin
                session_state_next = lbss_pkg::ST_READY;
              end else if (current_kind == lbss_pkg::MSG_QUERY) begin
                if (session_state == lbss_pkg::ST_PROGRESS) begin
                  report      = 1'b1;
                  report_code = lbss_pkg::EV_TIMEOUT;
                end
                session_state_next = lbss_pkg::ST_READY;
              end
            end
          end else begin
            countdown_next = countdown - TIMER_BITS'(1);
          end
        end
      end

      default: ;
    endcase

    // A reported event carries the request kind and data after the update.
    if (report) begin
      res.event_valid    = 1'b1;
      res.event_code     = report_code;
      res.event_msg_kind = current_kind_next;
      res.event_data     = stored_data_next;
    end
    res.busy_res = (session_state_next != lbss_pkg::ST_READY);
  end

  // Session state registers, updated as each word passes to the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      session_state     <= lbss_pkg::ST_READY;
      current_kind      <= lbss_pkg::MSG_SEND;
      repeat_pending    <= 1'b0;
      stored_frame_kind <= '0;
      stored_data       <= '0;
      countdown         <= '0;
      countdown_running <= 1'b0;
    end else if (step) begin
      session_state     <= session_state_next;
      current_kind      <= current_kind_next;
      repeat_pending    <= repeat_pending_next;
      stored_frame_kind <= stored_frame_kind_next;
      stored_data       <= stored_data_next;
      countdown         <= countdown_next;
      countdown_running <= countdown_running_next;
    end
  end

  // A stopped timer always rests at zero.
  `LBSS_ASSERT_SAME(a_timer_idle_zero, clk, rst, !countdown_running, countdown == '0)
  // Events never come with a failing request status.
  `LBSS_ASSERT_SAME(a_event_status_ok, clk, rst, step && res.event_valid,
                    res.exec_status == lbss_pkg::STAT_OK)
  // A frame is offered only with an accepted or refused status.
  `LBSS_ASSERT_SAME(a_send_status, clk, rst, step && res.send_strobe,
                    res.exec_status == lbss_pkg::STAT_OK ||
                    res.exec_status == lbss_pkg::STAT_REFUSED)
  // An accepted request puts the session in progress.
  `LBSS_ASSERT_NEXT(a_request_progress, clk, rst,
                    step && item.func == lbss_pkg::FUNC_REQUEST &&
                    res.exec_status == lbss_pkg::STAT_OK,
                    session_state == lbss_pkg::ST_PROGRESS)

endmodule

[rtl/lbss_out_reg.sv]
module lbss_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  lbss_pkg::out_t res,
  output logic          advance,
  output logic          out_valid,
  input  logic          out_stall,
  output lbss_pkg::out_t out_data
);

  // The result register can load when empty or when its word leaves now.
  assign advance = !out_valid || !out_stall;

  // Valid bit of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

endmodule
